// ----- rtl/lrbs_pkg.sv -----
// Shared types and constants for the loop region block segmenter.
`default_nettype none
package lrbs_pkg;
	localparam int POS_W    = 48;
	localparam int SEGPOS_W = 47;
	localparam int CFG_W    = 32;
	localparam int IDX_W    = 2;

	localparam logic [IDX_W-1:0] REG_LOOP_START = 2'd0;
	localparam logic [IDX_W-1:0] REG_LOOP_END   = 2'd1;
	localparam logic [IDX_W-1:0] REG_WAIT_START = 2'd2;

	typedef struct packed {
		logic [CFG_W-1:0] loop_start;
		logic [CFG_W-1:0] loop_end;
		logic [CFG_W-1:0] wait_start;
	} cfg_t;
endpackage
`default_nettype wire

// ----- rtl/lrbs_rem.sv -----
// Iterative restoring remainder unit, one dividend bit per cycle.
`default_nettype none
module lrbs_rem #(
	parameter int DVD_W = 47,
	parameter int DVS_W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic                  done,
	output logic [DVS_W-1:0]      remainder
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			if (!diff[DVS_W])
				rem_q <= diff[DVS_W-1:0];
			else
				rem_q <= trial[DVS_W-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

// ----- rtl/lrbs_front.sv -----
// Front end: takes a block, skips frames before the wait start, wraps the position.
`default_nettype none
module lrbs_front #(
	parameter int FRAME_W    = 13,
	parameter int OFFSET_W   = 12,
	parameter int MAX_FRAMES = 4096,
	parameter int JOB_W      = 72
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire lrbs_pkg::cfg_t                  cfg,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [lrbs_pkg::POS_W-1:0]      block_position,
	input  wire logic [FRAME_W-1:0]              frame_count,
	output logic                                 push,
	output logic [JOB_W-1:0]                     job,
	input  wire logic                            full
);
	localparam int POS_W    = lrbs_pkg::POS_W;
	localparam int SEGPOS_W = lrbs_pkg::SEGPOS_W;
	localparam int CFG_W    = lrbs_pkg::CFG_W;

	localparam logic [2:0] F_IDLE  = 3'd0;
	localparam logic [2:0] F_SKIP  = 3'd1;
	localparam logic [2:0] F_CLASS = 3'd2;
	localparam logic [2:0] F_DIV   = 3'd3;
	localparam logic [2:0] F_PUSH  = 3'd4;

	logic [2:0]          state_q;
	logic [POS_W-1:0]    pos_q;
	logic [FRAME_W-1:0]  total_q;
	logic [FRAME_W-1:0]  remain_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [SEGPOS_W-1:0] upos_q;

	logic [FRAME_W-1:0]  total_sat;
	logic [POS_W:0]      skip_d;
	logic                skip_pos;
	logic                skip_all;
	logic                loop_en;
	logic                wrap;
	logic                div_load;
	logic                div_done;
	logic [CFG_W-1:0]    div_rem;

	assign total_sat = (frame_count > FRAME_W'(MAX_FRAMES)) ? FRAME_W'(MAX_FRAMES) : frame_count;

	assign skip_d   = {{(POS_W+1-CFG_W){1'b0}}, cfg.wait_start} - {pos_q[POS_W-1], pos_q};
	assign skip_pos = !skip_d[POS_W] && (skip_d != '0);
	assign skip_all = skip_d[POS_W-1:0] >= {{(POS_W-FRAME_W){1'b0}}, total_q};

	assign loop_en  = cfg.loop_end > cfg.loop_start;
	assign wrap     = loop_en && (upos_q >= {{(SEGPOS_W-CFG_W){1'b0}}, cfg.loop_end});
	assign div_load = (state_q == F_CLASS) && wrap;

	lrbs_rem #(
		.DVD_W(SEGPOS_W),
		.DVS_W(CFG_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.dividend (upos_q - {{(SEGPOS_W-CFG_W){1'b0}}, cfg.loop_start}),
		.divisor  (cfg.loop_end - cfg.loop_start),
		.done     (div_done),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start)
						state_q <= F_SKIP;
				end
				F_SKIP: begin
					if (total_q == '0 || (skip_pos && skip_all))
						state_q <= F_IDLE;
					else
						state_q <= F_CLASS;
				end
				F_CLASS: begin
					state_q <= wrap ? F_DIV : F_PUSH;
				end
				F_DIV: begin
					if (div_done)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				pos_q   <= block_position;
				total_q <= total_sat;
			end
			F_SKIP: begin
				if (skip_pos) begin
					remain_q <= total_q - skip_d[FRAME_W-1:0];
					offset_q <= skip_d[OFFSET_W-1:0];
					upos_q   <= {{(SEGPOS_W-CFG_W){1'b0}}, cfg.wait_start};
				end else begin
					remain_q <= total_q;
					offset_q <= '0;
					upos_q   <= pos_q[SEGPOS_W-1:0];
				end
			end
			F_DIV: begin
				if (div_done)
					upos_q <= {{(SEGPOS_W-CFG_W){1'b0}}, cfg.loop_start + div_rem};
			end
			default: begin
			end
		endcase
	end

	assign busy = state_q != F_IDLE;
	assign push = (state_q == F_PUSH) && !full;
	assign job  = {upos_q, remain_q, offset_q};
endmodule
`default_nettype wire

// ----- rtl/lrbs_queue.sv -----
// Small register queue between the front and back ends.
`default_nettype none
module lrbs_queue #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  full,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	assign rdata = mem_q[rptr_q];
	assign full  = cnt_q == CNT_W'(DEPTH);
	assign empty = cnt_q == '0;
endmodule
`default_nettype wire

// ----- rtl/lrbs_back.sv -----
// Back end: splits a job at each loop end and emits one segment per cycle.
`default_nettype none
module lrbs_back #(
	parameter int FRAME_W      = 13,
	parameter int OFFSET_W     = 12,
	parameter int MAX_SEGMENTS = 64,
	parameter int JOB_W        = 72
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire lrbs_pkg::cfg_t                    cfg,
	input  wire logic [JOB_W-1:0]                  job,
	input  wire logic                              empty,
	output logic                                   pop,
	output logic                                   strobe,
	output logic [lrbs_pkg::SEGPOS_W-1:0]          segment_position,
	output logic [FRAME_W-1:0]                     segment_frames,
	output logic [OFFSET_W-1:0]                    buffer_offset,
	output logic                                   last,
	output logic                                   truncated
);
	localparam int SEGPOS_W = lrbs_pkg::SEGPOS_W;
	localparam int CFG_W    = lrbs_pkg::CFG_W;
	localparam int SEG_W    = $clog2(MAX_SEGMENTS);

	localparam logic B_IDLE = 1'b0;
	localparam logic B_RUN  = 1'b1;

	logic                state_q;
	logic [SEGPOS_W-1:0] pos_q;
	logic [FRAME_W-1:0]  remain_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [SEG_W-1:0]    cnt_q;

	logic                loop_en;
	logic [CFG_W-1:0]    lim;
	logic [CFG_W-1:0]    rem_ext;
	logic [FRAME_W-1:0]  seg;
	logic [FRAME_W-1:0]  rem_next;
	logic                at_cap;
	logic                is_last;

	logic                strobe_q;
	logic [SEGPOS_W-1:0] pos_o_q;
	logic [FRAME_W-1:0]  frames_o_q;
	logic [OFFSET_W-1:0] offset_o_q;
	logic                last_o_q;
	logic                trunc_o_q;

	assign loop_en  = cfg.loop_end > cfg.loop_start;
	assign lim      = cfg.loop_end - pos_q[CFG_W-1:0];
	assign rem_ext  = CFG_W'(remain_q);
	assign seg      = (!loop_en || rem_ext <= lim) ? remain_q : lim[FRAME_W-1:0];
	assign rem_next = remain_q - seg;
	assign at_cap   = cnt_q == SEG_W'(MAX_SEGMENTS - 1);
	assign is_last  = (rem_next == '0) || at_cap;
	assign pop      = (state_q == B_IDLE) && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= state_q == B_RUN;
			case (state_q)
				B_IDLE: begin
					if (!empty)
						state_q <= B_RUN;
				end
				B_RUN: begin
					if (is_last)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE) begin
			{pos_q, remain_q, offset_q} <= job;
			cnt_q <= '0;
		end else begin
			pos_o_q    <= pos_q;
			frames_o_q <= seg;
			offset_o_q <= offset_q;
			last_o_q   <= is_last;
			trunc_o_q  <= (rem_next != '0) && at_cap;
			pos_q      <= {{(SEGPOS_W-CFG_W){1'b0}}, cfg.loop_start};
			remain_q   <= rem_next;
			offset_q   <= offset_q + OFFSET_W'(seg);
			cnt_q      <= cnt_q + 1'b1;
		end
	end

	assign strobe           = strobe_q;
	assign segment_position = pos_o_q;
	assign segment_frames   = frames_o_q;
	assign buffer_offset    = offset_o_q;
	assign last             = last_o_q;
	assign truncated        = trunc_o_q;
endmodule
`default_nettype wire

// ----- rtl/loop_region_block_segmenter.sv -----
// Top level of the loop region block segmenter.
// A block is taken when start is high and busy is low; busy stays high while the
// front end works on it: the block is dropped when the frame count is zero or every
// frame lies before wait_start; a position at or past loop_end is wrapped by the
// bit-serial remainder unit (one bit of the 47-bit position per cycle); and the job
// is pushed once the two-entry job queue has room. The back end pops a job when idle,
// then works out one segment per cycle, each shown on strobe in the following cycle
// from the output register, up to MAX_SEGMENTS per block.
// Results are shown for one cycle only and cannot be held off; the receiver must
// take every strobed beat. Configuration writes are always ready and must only be
// made while no block is in flight.
`default_nettype none
module loop_region_block_segmenter #(
	parameter int MAX_FRAMES   = 4096,
	parameter int MAX_SEGMENTS = 64,
	parameter int FRAME_W      = $clog2(MAX_FRAMES + 1),
	parameter int OFFSET_W     = $clog2(MAX_FRAMES)
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [lrbs_pkg::IDX_W-1:0]       cfg_index,
	input  wire logic [lrbs_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [lrbs_pkg::POS_W-1:0]       block_position,
	input  wire logic [FRAME_W-1:0]               frame_count,
	output logic                                  strobe,
	output logic [lrbs_pkg::SEGPOS_W-1:0]         segment_position,
	output logic [FRAME_W-1:0]                    segment_frames,
	output logic [OFFSET_W-1:0]                   buffer_offset,
	output logic                                  last,
	output logic                                  truncated
);
	localparam int JOB_W = lrbs_pkg::SEGPOS_W + FRAME_W + OFFSET_W;

	lrbs_pkg::cfg_t   cfg_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	logic [JOB_W-1:0] q_wdata;
	logic [JOB_W-1:0] q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				lrbs_pkg::REG_LOOP_START: cfg_q.loop_start <= cfg_data;
				lrbs_pkg::REG_LOOP_END:   cfg_q.loop_end   <= cfg_data;
				lrbs_pkg::REG_WAIT_START: cfg_q.wait_start <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lrbs_front #(
		.FRAME_W   (FRAME_W),
		.OFFSET_W  (OFFSET_W),
		.MAX_FRAMES(MAX_FRAMES),
		.JOB_W     (JOB_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.start         (start),
		.busy          (busy),
		.block_position(block_position),
		.frame_count   (frame_count),
		.push          (q_push),
		.job           (q_wdata),
		.full          (q_full)
	);

	lrbs_queue #(
		.WIDTH(JOB_W),
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	lrbs_back #(
		.FRAME_W     (FRAME_W),
		.OFFSET_W    (OFFSET_W),
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.JOB_W       (JOB_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.job             (q_rdata),
		.empty           (q_empty),
		.pop             (q_pop),
		.strobe          (strobe),
		.segment_position(segment_position),
		.segment_frames  (segment_frames),
		.buffer_offset   (buffer_offset),
		.last            (last),
		.truncated       (truncated)
	);
endmodule
`default_nettype wire

// ----- rtl/lrbs_checker.sv -----
// Port-level checks for the loop region block segmenter, bound to the top level.
`default_nettype none
module lrbs_checker #(
	parameter int FRAME_W  = 13,
	parameter int OFFSET_W = 12
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                start,
	input wire logic                busy,
	input wire logic                strobe,
	input wire logic [FRAME_W-1:0]  segment_frames,
	input wire logic [OFFSET_W-1:0] buffer_offset,
	input wire logic                last,
	input wire logic                truncated
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a block was taken");

	a_trunc_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && truncated |-> last)
		else $error("truncated segment not marked last");

	a_frames_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> segment_frames != '0)
		else $error("empty segment emitted");

	a_segments_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe &&
			buffer_offset == OFFSET_W'($past(buffer_offset) + $past(segment_frames)))
		else $error("segments of one block not back to back");
endmodule

bind loop_region_block_segmenter lrbs_checker #(
	.FRAME_W (FRAME_W),
	.OFFSET_W(OFFSET_W)
) u_lrbs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.strobe        (strobe),
	.segment_frames(segment_frames),
	.buffer_offset (buffer_offset),
	.last          (last),
	.truncated     (truncated)
);
`default_nettype wire
